### hdl/ps2dl_pkg.sv
// Shared types, codes and helper functions for the PS/2 device-side link.
`timescale 1ns / 1ps

package ps2dl_pkg;

   localparam int TIMER_W = 11;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_TX_WCLK  = 5'd1,
      PH_TX_DELAY = 5'd2,
      PH_TX_SETUP = 5'd3,
      PH_TX_LOW   = 5'd4,
      PH_TX_HIGH  = 5'd5,
      PH_RX_WAIT  = 5'd6,
      PH_RX_SETUP = 5'd7,
      PH_RX_LOW   = 5'd8,
      PH_RX_HIGH  = 5'd9,
      PH_ACK_HALF = 5'd10,
      PH_ACK_SET  = 5'd11,
      PH_ACK_LOW  = 5'd12,
      PH_ACK_HIGH = 5'd13
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_HOST_DATA  = 3'd1,
      ST_CLK_INHIB  = 3'd2,
      ST_NO_REQUEST = 3'd3,
      ST_TIMEOUT    = 3'd4,
      ST_FRAMING    = 3'd5
   } status_type;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SEND = 2'd1;
   localparam logic [1:0] FUNC_RECV = 2'd2;

   localparam logic [1:0] DRV_NONE = 2'b00;
   localparam logic [1:0] DRV_CLK  = 2'b01;
   localparam logic [1:0] DRV_DATA = 2'b10;

   localparam logic [2:0] CSR_HALF_PHASE  = 3'd0;
   localparam logic [2:0] CSR_FULL_PHASE  = 3'd1;
   localparam logic [2:0] CSR_START_DELAY = 3'd2;
   localparam logic [2:0] CSR_HOST_WAIT   = 3'd3;
   localparam logic [2:0] CSR_ACK_SETUP   = 3'd4;

   localparam logic [7:0] RST_HALF_PHASE  = 8'd20;
   localparam logic [7:0] RST_FULL_PHASE  = 8'd40;
   localparam logic [7:0] RST_START_DELAY = 8'd50;
   localparam logic [9:0] RST_HOST_WAIT   = 10'd555;
   localparam logic [7:0] RST_ACK_SETUP   = 8'd1;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] tx_byte;
      logic       clk_in;
      logic       data_in;
   } req_type;

   typedef struct packed {
      logic       clk_low;
      logic       data_low;
      logic       busy_res;
      logic       done_res;
      status_type status;
      logic [7:0] rx_byte;
      logic       parity_error;
   } rsp_type;

   typedef struct packed {
      logic [7:0] half_phase_ticks;
      logic [7:0] full_phase_ticks;
      logic [7:0] start_delay_ticks;
      logic [9:0] host_wait_limit;
      logic [7:0] ack_setup_ticks;
   } cfg_type;

   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic logic is_timed(input phase_type p);
      return (p == PH_TX_DELAY) || (p == PH_TX_SETUP) || (p == PH_TX_LOW) ||
             (p == PH_TX_HIGH) || (p == PH_RX_SETUP) || (p == PH_RX_LOW) ||
             (p == PH_RX_HIGH) || (p == PH_ACK_HALF) || (p == PH_ACK_SET) ||
             (p == PH_ACK_LOW) || (p == PH_ACK_HIGH);
   endfunction

   function automatic logic [7:0] phase_len(input phase_type p, input cfg_type c);
      logic [7:0] len;
      case (p)
         PH_TX_DELAY: len = c.start_delay_ticks;
         PH_TX_LOW, PH_RX_LOW, PH_ACK_LOW: len = at_least_one(c.full_phase_ticks);
         PH_ACK_SET:  len = c.ack_setup_ticks;
         default:     len = at_least_one(c.half_phase_ticks);
      endcase
      return len;
   endfunction

endpackage

### hdl/ps2dl_engine.sv
// Link state machine: per-tick line sequencing for send, receive and acknowledge.
`timescale 1ns / 1ps

module ps2dl_engine import ps2dl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type          phase_ff,  phase_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [7:0]         shift_ff,  shift_in;
   logic               parity_ff, parity_in;
   logic [TIMER_W-1:0] timer_ff,  timer_in;
   logic [1:0]         drive_ff,  drive_in;

   logic       fin;
   status_type fin_status;
   logic [7:0] fin_rx;
   logic       fin_perr;
   logic       do_level;
   logic       tx_bit;
   logic       clk_s, dat_s;

   assign clk_s = req.clk_in;
   assign dat_s = req.data_in;

   always_comb begin
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      parity_in  = parity_ff;
      timer_in   = timer_ff;
      drive_in   = drive_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_rx     = 8'd0;
      fin_perr   = 1'b0;
      do_level   = 1'b0;
      tx_bit     = 1'b0;

      // request intake, timer advance or level wait
      if (phase_ff == PH_IDLE) begin
         if (req.func == FUNC_SEND) begin
            shift_in   = req.tx_byte;
            bit_cnt_in = 4'd0;
            parity_in  = 1'b1;
            phase_in   = PH_TX_WCLK;
            timer_in   = '0;
            drive_in   = DRV_NONE;
            do_level   = 1'b1;
         end else if (req.func == FUNC_RECV) begin
            shift_in   = 8'd0;
            bit_cnt_in = 4'd0;
            parity_in  = 1'b0;
            phase_in   = PH_RX_WAIT;
            timer_in   = '0;
            drive_in   = DRV_NONE;
            do_level   = 1'b1;
         end
      end else if (is_timed(phase_ff)) begin
         timer_in = timer_ff + TIMER_W'(1);
      end else begin
         do_level = 1'b1;
      end

      if (do_level) begin
         if (phase_in == PH_TX_WCLK) begin
            if (clk_s) begin
               phase_in = PH_TX_DELAY;
               timer_in = '0;
               drive_in = DRV_NONE;
            end
         end else if (phase_in == PH_RX_WAIT) begin
            if (clk_s) begin
               if (dat_s) begin
                  fin = 1'b1; fin_status = ST_NO_REQUEST;
                  phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
               end else begin
                  bit_cnt_in = 4'd0;
                  phase_in   = PH_RX_SETUP;
                  timer_in   = '0;
                  drive_in   = DRV_NONE;
               end
            end else if (timer_in > TIMER_W'(cfg.host_wait_limit)) begin
               fin = 1'b1; fin_status = ST_TIMEOUT;
               phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
            end else begin
               timer_in = timer_in + TIMER_W'(1);
            end
         end
      end

      // zero-length phases chain at most twice in one tick
      for (int i = 0; i < 2; i++) begin
         if (is_timed(phase_in) &&
             timer_in >= TIMER_W'(phase_len(phase_in, cfg))) begin
            unique case (phase_in)
               PH_TX_DELAY: begin
                  if (!dat_s) begin
                     fin = 1'b1; fin_status = ST_HOST_DATA;
                     phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
                  end else begin
                     bit_cnt_in = 4'd0;
                     phase_in   = PH_TX_SETUP;
                     timer_in   = '0;
                     drive_in   = DRV_DATA;   // start bit is 0
                  end
               end
               PH_TX_SETUP: begin
                  phase_in = PH_TX_LOW; timer_in = '0; drive_in = drive_in | DRV_CLK;
               end
               PH_TX_LOW: begin
                  phase_in = PH_TX_HIGH; timer_in = '0; drive_in = drive_in & DRV_DATA;
               end
               PH_TX_HIGH: begin
                  if (bit_cnt_in >= 4'd10) begin
                     fin = 1'b1; fin_status = ST_OK;
                     phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
                  end else if (!clk_s) begin
                     fin = 1'b1; fin_status = ST_CLK_INHIB;
                     phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
                  end else begin
                     if (bit_cnt_in >= 4'd1 && bit_cnt_in <= 4'd8) begin
                        parity_in = parity_in ^ shift_in[0];
                        shift_in  = {1'b0, shift_in[7:1]};
                     end
                     bit_cnt_in = bit_cnt_in + 4'd1;
                     if (bit_cnt_in == 4'd0)      tx_bit = 1'b0;
                     else if (bit_cnt_in <= 4'd8) tx_bit = shift_in[0];
                     else if (bit_cnt_in == 4'd9) tx_bit = parity_in;
                     else                         tx_bit = 1'b1;
                     phase_in = PH_TX_SETUP;
                     timer_in = '0;
                     drive_in = tx_bit ? DRV_NONE : DRV_DATA;
                  end
               end
               PH_RX_SETUP: begin
                  phase_in = PH_RX_LOW; timer_in = '0; drive_in = DRV_CLK;
               end
               PH_RX_LOW: begin
                  phase_in = PH_RX_HIGH; timer_in = '0; drive_in = DRV_NONE;
               end
               PH_RX_HIGH: begin
                  if (bit_cnt_in < 4'd8) begin
                     if (!clk_s) begin
                        fin = 1'b1; fin_status = ST_CLK_INHIB;
                        phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
                     end else begin
                        shift_in   = {dat_s, shift_in[7:1]};
                        parity_in  = parity_in ^ dat_s;
                        bit_cnt_in = bit_cnt_in + 4'd1;
                        phase_in = PH_RX_SETUP; timer_in = '0; drive_in = DRV_NONE;
                     end
                  end else if (bit_cnt_in == 4'd8) begin
                     // flag holds 1 when data plus parity has even weight
                     parity_in  = ~(parity_in ^ dat_s);
                     bit_cnt_in = 4'd9;
                     phase_in = PH_RX_SETUP; timer_in = '0; drive_in = DRV_NONE;
                  end else if (bit_cnt_in == 4'd9) begin
                     if (dat_s) begin
                        phase_in = PH_ACK_HALF; timer_in = '0; drive_in = DRV_NONE;
                     end else begin
                        bit_cnt_in = 4'd10;
                        phase_in = PH_RX_SETUP; timer_in = '0; drive_in = DRV_NONE;
                     end
                  end else begin
                     // hunting for a high data bit after a missing stop bit
                     if (dat_s) begin
                        fin = 1'b1; fin_status = ST_FRAMING; fin_perr = parity_in;
                        phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
                     end else begin
                        phase_in = PH_RX_SETUP; timer_in = '0; drive_in = DRV_NONE;
                     end
                  end
               end
               PH_ACK_HALF: begin
                  phase_in = PH_ACK_SET; timer_in = '0; drive_in = DRV_DATA;
               end
               PH_ACK_SET: begin
                  phase_in = PH_ACK_LOW; timer_in = '0; drive_in = DRV_DATA | DRV_CLK;
               end
               PH_ACK_LOW: begin
                  phase_in = PH_ACK_HIGH; timer_in = '0; drive_in = DRV_DATA;
               end
               PH_ACK_HIGH: begin
                  fin = 1'b1; fin_status = ST_OK; fin_rx = shift_in; fin_perr = parity_in;
                  phase_in = PH_IDLE; timer_in = '0; drive_in = DRV_NONE;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp.clk_low      = drive_in[0];
      rsp.data_low     = drive_in[1];
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.done_res     = fin;
      rsp.status       = fin_status;
      rsp.rx_byte      = fin_rx;
      rsp.parity_error = fin_perr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_cnt_ff <= 4'd0;
         shift_ff   <= 8'd0;
         parity_ff  <= 1'b0;
         timer_ff   <= '0;
         drive_ff   <= DRV_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         parity_ff  <= parity_in;
         timer_ff   <= timer_in;
         drive_ff   <= drive_in;
      end
   end

endmodule

### hdl/ps2_device_side_link_unit.sv
// Top level: register file, link engine and two-entry result buffer.
// An accepted item's result is registered in the output register or in the skid entry.
// One tick item per clock unless req_stall; result path: an output register plus skid.
// req_stall rises only when both result entries are full.
// Synchronous active-high reset: link idle, lines released, registers to defaults.
`timescale 1ns / 1ps

module ps2_device_side_link_unit import ps2dl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_data
);

   cfg_type cfg_ff;
   rsp_type step_rsp;
   rsp_type out_ff, skid_ff;
   logic    out_vld_ff, skid_vld_ff;
   logic    accept, take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !skid_vld_ff;
   assign take      = out_vld_ff && !rsp_stall;
   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_phase_ticks  <= RST_HALF_PHASE;
         cfg_ff.full_phase_ticks  <= RST_FULL_PHASE;
         cfg_ff.start_delay_ticks <= RST_START_DELAY;
         cfg_ff.host_wait_limit   <= RST_HOST_WAIT;
         cfg_ff.ack_setup_ticks   <= RST_ACK_SETUP;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_PHASE:  cfg_ff.half_phase_ticks  <= csr_data[7:0];
            CSR_FULL_PHASE:  cfg_ff.full_phase_ticks  <= csr_data[7:0];
            CSR_START_DELAY: cfg_ff.start_delay_ticks <= csr_data[7:0];
            CSR_HOST_WAIT:   cfg_ff.host_wait_limit   <= csr_data;
            CSR_ACK_SETUP:   cfg_ff.ack_setup_ticks   <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   ps2dl_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .rsp   (step_rsp)
   );

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (accept) begin
         if (!out_vld_ff || take) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_vld_ff || take) begin
            out_ff <= step_rsp;
         end else begin
            skid_ff <= step_rsp;
         end
      end else if (take && skid_vld_ff) begin
         out_ff <= skid_ff;
      end
   end

endmodule
